### hw/rtl/atup_pkg.sv
`default_nettype none

package atup_pkg;

	// Result and position widths
	localparam int VALUE_WIDTH  = 64;
	localparam int OFFSET_WIDTH = 16;
	localparam int BASE_WIDTH   = 6;
	localparam int DIGIT_WIDTH  = 6;
	localparam int CHAR_WIDTH   = 8;
	localparam int PROD_WIDTH   = VALUE_WIDTH + BASE_WIDTH;

	// Output beat packing: value, end_offset, converted, overflow
	localparam int OUT_BITS     = VALUE_WIDTH + OFFSET_WIDTH + 2;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

	// Radix values
	localparam logic [BASE_WIDTH-1:0] BASE_RESET = BASE_WIDTH'(10);
	localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = BASE_WIDTH'(0);
	localparam logic [BASE_WIDTH-1:0] BASE_OCT   = BASE_WIDTH'(8);
	localparam logic [BASE_WIDTH-1:0] BASE_DEC   = BASE_WIDTH'(10);
	localparam logic [BASE_WIDTH-1:0] BASE_HEX   = BASE_WIDTH'(16);

	// Character codes
	localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5a;
	localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7a;
	localparam logic [CHAR_WIDTH-1:0] LETTER_BIAS = 8'd10;

	// Character classification passed from the decoder to the core
	typedef struct packed {
		logic                   is_space;
		logic                   is_minus;
		logic                   is_plus;
		logic                   is_zero;
		logic                   is_x;
		logic                   is_alnum;
		logic [DIGIT_WIDTH-1:0] digit;
	} char_class_t;

	// One result item, value in the low bits
	typedef struct packed {
		logic                    overflow;
		logic                    converted;
		logic [OFFSET_WIDTH-1:0] end_offset;
		logic [VALUE_WIDTH-1:0]  value;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/atup_classify.sv
`default_nettype none

module atup_classify (
	input  wire logic [atup_pkg::CHAR_WIDTH-1:0] ch,
	output atup_pkg::char_class_t                cls
);
	import atup_pkg::*;

	logic is_num;
	logic is_upper;
	logic is_lower;
	logic [CHAR_WIDTH-1:0] dval;

	// Decode punctuation, whitespace and digit value
	always_comb begin
		is_num   = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_upper = (ch >= CH_UA) && (ch <= CH_UZ);
		is_lower = (ch >= CH_LA) && (ch <= CH_LZ);
		if (is_num) begin
			dval = ch - CH_ZERO;
		end else if (is_upper) begin
			dval = ch - CH_UA + LETTER_BIAS;
		end else begin
			dval = ch - CH_LA + LETTER_BIAS;
		end
		cls.is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
		cls.is_minus = (ch == CH_MINUS);
		cls.is_plus  = (ch == CH_PLUS);
		cls.is_zero  = (ch == CH_ZERO);
		cls.is_x     = (ch == CH_LX) || (ch == CH_UX);
		cls.is_alnum = is_num || is_upper || is_lower;
		cls.digit    = dval[DIGIT_WIDTH-1:0];
	end

endmodule

`default_nettype wire

### hw/rtl/atup_core.sv
`default_nettype none

module atup_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step_en,
	input  wire logic                            start,
	input  wire atup_pkg::char_class_t           cls,
	input  wire logic [atup_pkg::BASE_WIDTH-1:0] number_base,
	output logic                                 res_valid,
	output atup_pkg::result_t                    res
);
	import atup_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_SIGNED,
		PH_PREFIX,
		PH_DIGITS
	} phase_t;

	localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;

	phase_t                  phase_q, ph, ph_n;
	logic [VALUE_WIDTH-1:0]  acc_q, acc, acc_n;
	logic                    neg_q, neg, neg_n;
	logic                    saw_q, saw, saw_n;
	logic                    sat_q, sat, sat_n;
	logic [BASE_WIDTH-1:0]   base_q, base, base_n;
	logic [OFFSET_WIDTH-1:0] pos_q, pos;
	logic                    first;
	logic                    use_digit;
	logic                    saw_eff;
	logic [BASE_WIDTH-1:0]   wb_eff;
	logic [PROD_WIDTH-1:0]   prod;

	// Step the parser by one character
	always_comb begin
		// Begin a new string on start, else carry the held state
		ph   = start ? PH_SPACE : phase_q;
		acc  = start ? '0 : acc_q;
		neg  = start ? 1'b0 : neg_q;
		saw  = start ? 1'b0 : saw_q;
		sat  = start ? 1'b0 : sat_q;
		base = start ? number_base : base_q;
		if (start) begin
			pos = '0;
		end else if (phase_q != PH_IDLE && pos_q != POS_MAX) begin
			pos = pos_q + 1'b1;
		end else begin
			pos = pos_q;
		end

		ph_n      = ph;
		acc_n     = acc;
		neg_n     = neg;
		saw_n     = saw;
		sat_n     = sat;
		base_n    = base;
		first     = 1'b0;
		use_digit = 1'b0;
		saw_eff   = saw;
		wb_eff    = base;
		res_valid = 1'b0;

		unique case (ph)
			PH_IDLE: begin
			end
			PH_SPACE: begin
				if (cls.is_space) begin
				end else if (cls.is_minus) begin
					neg_n = 1'b1;
					ph_n  = PH_SIGNED;
				end else if (cls.is_plus) begin
					ph_n = PH_SIGNED;
				end else begin
					first = 1'b1;
				end
			end
			PH_SIGNED: begin
				first = 1'b1;
			end
			PH_PREFIX: begin
				if (cls.is_x) begin
					base_n = BASE_HEX;
					ph_n   = PH_DIGITS;
				end else begin
					// The leading zero counts as a digit
					if (base == BASE_AUTO) begin
						wb_eff = BASE_OCT;
					end
					saw_eff   = 1'b1;
					use_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				use_digit = 1'b1;
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		// First character after whitespace and sign
		if (first) begin
			if ((base == BASE_AUTO || base == BASE_HEX) && cls.is_zero) begin
				ph_n = PH_PREFIX;
			end else begin
				wb_eff    = (base == BASE_AUTO) ? BASE_DEC : base;
				use_digit = 1'b1;
			end
		end

		// Multiply-add; any bit above the value width means overflow
		prod = PROD_WIDTH'(acc) * PROD_WIDTH'(wb_eff) + PROD_WIDTH'(cls.digit);

		res.value      = (neg && saw_eff && !sat) ? (VALUE_WIDTH'(0) - acc) : acc;
		res.end_offset = saw_eff ? pos : '0;
		res.converted  = saw_eff;
		res.overflow   = sat;

		if (use_digit) begin
			base_n = wb_eff;
			saw_n  = saw_eff;
			if (!cls.is_alnum || cls.digit >= wb_eff) begin
				// Terminating character: emit and go idle
				res_valid = 1'b1;
				ph_n      = PH_IDLE;
			end else begin
				ph_n  = PH_DIGITS;
				saw_n = 1'b1;
				if (!sat) begin
					if (|prod[PROD_WIDTH-1:VALUE_WIDTH]) begin
						sat_n = 1'b1;
						acc_n = '1;
					end else begin
						acc_n = prod[VALUE_WIDTH-1:0];
					end
				end
			end
		end
	end

	// Hold parser state between characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			saw_q   <= 1'b0;
			sat_q   <= 1'b0;
			base_q  <= '0;
			pos_q   <= '0;
		end else if (step_en) begin
			phase_q <= ph_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			saw_q   <= saw_n;
			sat_q   <= sat_n;
			base_q  <= base_n;
			pos_q   <= pos;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ascii_to_unsigned_parser.sv
// A terminating character passes the input register; the result register then sets m_tvalid.
// Throughput: one character per cycle while not stalled; the 64x6 multiply-add with overflow
// check is combinational between the input register and the result register.
// A waiting result does not stop intake unless the input register is also full.
// Reset: arst_n clears the parser to idle, drops both registers, and sets number_base to 10.
`default_nettype none

module ascii_to_unsigned_parser (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [atup_pkg::BASE_WIDTH-1:0]     cfg_wdata,   // number_base
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [atup_pkg::CHAR_WIDTH-1:0]     s_tdata,     // [7:0] ch
	input  wire logic                                s_tuser,     // start_req
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// value, end_offset, converted, overflow from bit 0 up, zero padded
	output logic [atup_pkg::OUT_TDATA_W-1:0]         m_tdata
);
	import atup_pkg::*;

	logic [BASE_WIDTH-1:0] number_base_q;
	logic                  valid_s1;
	logic [CHAR_WIDTH-1:0] ch_s1;
	logic                  start_s1;
	logic                  advance;
	logic                  res_valid;
	char_class_t           cls;
	result_t               res;
	result_t               res_q;

	// Process the held beat when the result register is free or draining
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tdata  = OUT_TDATA_W'(res_q);

	// Hold the radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_RESET;
		end else if (cfg_we) begin
			number_base_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1    <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	atup_classify u_classify (
		.ch  (ch_s1),
		.cls (cls)
	);

	atup_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.start       (start_s1),
		.cls         (cls),
		.number_base (number_base_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance && res_valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	// Overflow only follows accepted digits
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!res_q.overflow || res_q.converted))
		else $error("overflow reported without converted digits");

	// Nothing converted means a zero value and zero offset
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_q.converted) |-> (res_q.value == '0 && res_q.end_offset == '0))
		else $error("empty conversion with nonzero fields");

	// Intake stalls only when both registers are full and the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a full pipeline");

	// A held result is not overwritten while waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !advance)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### tb/ascii_to_unsigned_parser_tb.sv
`default_nettype none

module ascii_to_unsigned_parser_tb;
	import atup_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int RANDOM_ITEMS   = 1100;
	localparam int CALM_TAIL      = 300;
	localparam int PHASE_ITEMS    = 90;

	typedef enum logic [2:0] {
		P_IDLE,
		P_BLANK,
		P_SIGN,
		P_PREFIX,
		P_DIGITS
	} scan_phase_e;

	// Tracks the parser state per accepted character and holds the numbers it must emit
	class strtoul_scoreboard;
		result_t                 expected_numbers[$];
		int                      errors;
		int                      results_seen;
		int                      saturated_seen;
		logic [BASE_WIDTH-1:0]   radix;
		scan_phase_e             phase;
		logic [VALUE_WIDTH-1:0]  acc;
		logic                    minus;
		logic                    any_digit;
		logic                    clipped;
		logic [BASE_WIDTH-1:0]   digit_base;
		logic [OFFSET_WIDTH-1:0] position;

		function new();
			radix          = BASE_RESET;
			phase          = P_IDLE;
			acc            = '0;
			minus          = 1'b0;
			any_digit      = 1'b0;
			clipped        = 1'b0;
			digit_base     = '0;
			position       = '0;
			errors         = 0;
			results_seen   = 0;
			saturated_seen = 0;
		endfunction

		function void set_radix(logic [BASE_WIDTH-1:0] b);
			radix = b;
		endfunction

		function int pending();
			return expected_numbers.size();
		endfunction

		// Multiply-add one digit; clip to all ones once the value no longer fits
		function void add_digit(int unsigned d);
			logic [VALUE_WIDTH-1:0] vmax;
			logic [VALUE_WIDTH-1:0] b;
			logic [VALUE_WIDTH-1:0] cutoff;
			logic [VALUE_WIDTH-1:0] cutlim;
			vmax   = '1;
			b      = VALUE_WIDTH'(digit_base);
			cutoff = vmax / b;
			cutlim = vmax % b;
			any_digit = 1'b1;
			if (clipped)
				return;
			if (acc > cutoff || (acc == cutoff && d > cutlim)) begin
				clipped = 1'b1;
				acc     = vmax;
			end else begin
				acc = acc * b + VALUE_WIDTH'(d);
			end
		endfunction

		// Accumulate a digit, or close the number on anything that is not one
		function void take_digit(logic [CHAR_WIDTH-1:0] c);
			int unsigned d;
			result_t     r;
			if (c >= CH_ZERO && c <= CH_NINE)
				d = c - CH_ZERO;
			else if (c >= CH_UA && c <= CH_UZ)
				d = c - CH_UA + LETTER_BIAS;
			else if (c >= CH_LA && c <= CH_LZ)
				d = c - CH_LA + LETTER_BIAS;
			else
				d = 64;
			if (d >= digit_base) begin
				r.value      = (minus && any_digit && !clipped) ? -acc : acc;
				r.end_offset = any_digit ? position : '0;
				r.converted  = any_digit;
				r.overflow   = clipped;
				expected_numbers.push_back(r);
				phase = P_IDLE;
			end else begin
				add_digit(d);
				phase = P_DIGITS;
			end
		endfunction

		// First character after blanks and sign: a zero may open a prefix
		function void take_lead(logic [CHAR_WIDTH-1:0] c);
			if ((digit_base == BASE_AUTO || digit_base == BASE_HEX) && c == CH_ZERO) begin
				phase = P_PREFIX;
				return;
			end
			if (digit_base == BASE_AUTO)
				digit_base = BASE_DEC;
			take_digit(c);
		endfunction

		function void note_char(logic [CHAR_WIDTH-1:0] c, logic first);
			if (first) begin
				phase      = P_BLANK;
				acc        = '0;
				minus      = 1'b0;
				any_digit  = 1'b0;
				clipped    = 1'b0;
				digit_base = radix;
				position   = '0;
			end else begin
				if (phase == P_IDLE)
					return;
				if (position != '1)
					position++;
			end
			case (phase)
				P_BLANK: begin
					if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
						return;
					if (c == CH_MINUS) begin
						minus = 1'b1;
						phase = P_SIGN;
						return;
					end
					if (c == CH_PLUS) begin
						phase = P_SIGN;
						return;
					end
					take_lead(c);
				end
				P_SIGN: take_lead(c);
				P_PREFIX: begin
					if (c == CH_LX || c == CH_UX) begin
						digit_base = BASE_HEX;
						phase      = P_DIGITS;
						return;
					end
					if (digit_base == BASE_AUTO)
						digit_base = BASE_OCT;
					add_digit(0);
					take_digit(c);
				end
				default: take_digit(c);
			endcase
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] beat);
			result_t got;
			result_t want;
			got = beat[OUT_BITS-1:0];
			results_seen++;
			if (expected_numbers.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, value %h", $time, got.value);
				return;
			end
			want = expected_numbers.pop_front();
			if (want.overflow)
				saturated_seen++;
			if (got.value !== want.value) begin
				errors++;
				$display("%0t: value expected %h actual %h", $time, want.value, got.value);
			end
			if (got.end_offset !== want.end_offset) begin
				errors++;
				$display("%0t: end_offset expected %0d actual %0d", $time,
					want.end_offset, got.end_offset);
			end
			if (got.converted !== want.converted) begin
				errors++;
				$display("%0t: converted expected %b actual %b", $time,
					want.converted, got.converted);
			end
			if (got.overflow !== want.overflow) begin
				errors++;
				$display("%0t: overflow expected %b actual %b", $time,
					want.overflow, got.overflow);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [BASE_WIDTH-1:0]  cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [CHAR_WIDTH-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	strtoul_scoreboard sb = new();

	bit          src_gaps;
	bit          snk_gaps;
	bit          lead;
	int unsigned chars_sent;
	int unsigned radix_writes;

	ascii_to_unsigned_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	// Sample both beat streams and register writes on the same edge the block sees them
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (s_tvalid && s_tready)
			sb.note_char(s_tdata, s_tuser);
		if (cfg_we)
			sb.set_radix(cfg_wdata);
	end

	// Result sink: ready with random stall bursts
	initial begin : sink
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (snk_gaps && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// End the run when no beat moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n === 1'b1 && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
				idle_cycles++;
			else
				idle_cycles = 0;
		end
		$display("%0t: timeout, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one character beat, after an optional gap, and hold it until taken
	task automatic drive_char(input logic [CHAR_WIDTH-1:0] c, input logic first);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic push(input logic [CHAR_WIDTH-1:0] c);
		drive_char(c, lead);
		lead = 1'b0;
		chars_sent++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push(s[i]);
	endtask

	// Stop sending and wait until every expected number has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_radix(input logic [BASE_WIDTH-1:0] b);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_writes++;
	endtask

	function automatic logic [CHAR_WIDTH-1:0] digit_char_for(int unsigned v);
		if (v < 10)
			return CHAR_WIDTH'(CH_ZERO + v);
		return CHAR_WIDTH'((($urandom_range(0, 1) != 0) ? CH_LA : CH_UA) + v - LETTER_BIAS);
	endfunction

	// One number string: blanks, sign, prefix, digits, then, unless unfinished, a random closing byte
	task automatic send_number(input logic [BASE_WIDTH-1:0] b, input bit unfinished);
		int unsigned eff;
		int unsigned len;
		lead = 1'b1;
		repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
			push(($urandom_range(0, 5) == 0) ? CH_SPACE :
				CHAR_WIDTH'(CH_TAB + $urandom_range(0, 4)));
		case ($urandom_range(0, 3))
			0: push(CH_MINUS);
			1: push(CH_PLUS);
			default: ;
		endcase
		eff = (b > 36) ? 36 : b;
		if (b == BASE_AUTO || b == BASE_HEX) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					push(CH_ZERO);
					push(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
					eff = 16;
				end
				2: begin
					push(CH_ZERO);
					eff = (b == BASE_AUTO) ? 8 : 16;
				end
				default: eff = (b == BASE_AUTO) ? 10 : 16;
			endcase
		end
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 70) : $urandom_range(0, 6);
		repeat (len)
			push(digit_char_for($urandom_range(0, eff - 1)));
		if (!unfinished)
			push(CHAR_WIDTH'($urandom_range(0, 255)));
	endtask

	// Stray bytes with no start flag
	task automatic spray();
		repeat ($urandom_range(1, 4))
			drive_char(CHAR_WIDTH'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic run_random(input logic [BASE_WIDTH-1:0] b, input int unsigned items);
		int unsigned stop;
		stop = chars_sent + items;
		program_radix(b);
		while (chars_sent < stop) begin
			case ($urandom_range(0, 9))
				0: spray();
				1: send_number(b, 1'b1);
				default: send_number(b, 1'b0);
			endcase
		end
	endtask

	initial begin : stimulus
		logic [BASE_WIDTH-1:0] plan [12];
		int                    p;
		int unsigned           rnd_start;
		plan = '{BASE_DEC, BASE_HEX, BASE_AUTO, BASE_OCT, BASE_WIDTH'(2), BASE_WIDTH'(36),
			BASE_WIDTH'(1), BASE_WIDTH'(63), BASE_WIDTH'(37), BASE_WIDTH'(7),
			BASE_AUTO, BASE_HEX};
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		src_gaps   = 1'b1;
		snk_gaps   = 1'b1;
		lead       = 1'b0;
		chars_sent = 0;
		radix_writes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Byte with no string open is dropped
		drive_char(8'hff, 1'b0);
		// Blanks, minus, digits, closed by a NUL byte
		lead = 1'b1;
		push_text(" \t-12");
		push(8'h00);
		// Restart in mid-string, then plus sign, closed by 0xff
		lead = 1'b1;
		push_text("57");
		lead = 1'b1;
		push_text("+9");
		push(8'hff);
		// Radix change while a string is open applies only to the next one
		lead = 1'b1;
		push_text("12");
		program_radix(BASE_HEX);
		push_text("f");
		// Prefix with no hex digit after it
		lead = 1'b1;
		push_text("0xg");
		// Auto radix picks octal after a leading zero
		program_radix(BASE_AUTO);
		lead = 1'b1;
		push_text("078");
		// Radix one takes zeros only; radix 63 takes every letter
		program_radix(BASE_WIDTH'(1));
		lead = 1'b1;
		push_text("01");
		program_radix(BASE_WIDTH'(63));
		lead = 1'b1;
		push_text("zZ");
		push(CH_CR);

		// Random phases over many radix settings, calm at the tail
		rnd_start = chars_sent;
		p = 0;
		while (chars_sent - rnd_start < RANDOM_ITEMS) begin
			if (chars_sent - rnd_start >= RANDOM_ITEMS - CALM_TAIL) begin
				src_gaps = 1'b0;
				snk_gaps = 1'b0;
			end else begin
				src_gaps = ($urandom_range(0, 3) != 0);
				snk_gaps = ($urandom_range(0, 3) != 0);
			end
			run_random((p < 12) ? plan[p] : BASE_WIDTH'($urandom_range(0, 63)), PHASE_ITEMS);
			p++;
		end
		settle();

		$display("Sent %0d characters over %0d radix writes, with restarts and stray bytes;",
			chars_sent, radix_writes);
		$display("checked %0d numbers, %0d of them saturated.", sb.results_seen,
			sb.saturated_seen);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
